>>> src/vtcm_pkg.sv
// ----------------------------------------------------------------------------
// vtcm_pkg: shared types and constants of the vario tone curve mapper
// Table entry layout, interpolation unit handshake, zone and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vtcm_pkg;

    localparam int MAX_POINTS_DEF = 16;

    localparam int SPEED_W = 16;
    localparam int FREQ_W  = 12;
    localparam int CYCLE_W = 16;
    localparam int DUTY_W  = 7;
    localparam int INDEX_W = 4;
    localparam int VAL_W   = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W    = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_ON_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIMB_OFF_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SINK_ON_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_LIFT_ENABLE = 3'd4;

    localparam logic [COUNT_W-1:0]        RST_POINT_COUNT     = 5'd0;
    localparam logic signed [SPEED_W-1:0] RST_CLIMB_ON_LEVEL  = 16'sd38;
    localparam logic signed [SPEED_W-1:0] RST_CLIMB_OFF_LEVEL = 16'sd13;
    localparam logic signed [SPEED_W-1:0] RST_SINK_ON_LEVEL   = -16'sd512;
    localparam logic                      RST_PRE_LIFT_ENABLE = 1'b1;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    localparam logic [1:0] ZONE_SILENCE  = 2'd0;
    localparam logic [1:0] ZONE_CLIMB    = 2'd1;
    localparam logic [1:0] ZONE_SINK     = 2'd2;
    localparam logic [1:0] ZONE_PRE_LIFT = 2'd3;

    localparam logic [FREQ_W-1:0]  PRE_LIFT_FREQ  = 12'd400;
    localparam logic [CYCLE_W-1:0] PRE_LIFT_CYCLE = 16'd1000;
    localparam logic [DUTY_W-1:0]  PRE_LIFT_DUTY  = 7'd5;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed;
        logic [FREQ_W-1:0]         freq;
        logic [CYCLE_W-1:0]        cycle;
        logic [DUTY_W-1:0]         duty;
    } tbl_entry_t;

    typedef struct packed {
        logic             start;
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic [VAL_W-1:0] t;
        logic [VAL_W-1:0] span;
    } lerp_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] result;
    } lerp_stat_t;

endpackage

`default_nettype wire

>>> src/vtcm_req_if.sv
// ----------------------------------------------------------------------------
// vtcm_req_if: request channel of the vario tone curve mapper
// Carries table point writes and speed evaluations.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtcm_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 req_type;
    logic signed [vtcm_pkg::SPEED_W-1:0]  vario;
    logic [vtcm_pkg::INDEX_W-1:0]         point_index;
    logic signed [vtcm_pkg::SPEED_W-1:0]  point_speed;
    logic [vtcm_pkg::FREQ_W-1:0]          point_freq;
    logic [vtcm_pkg::CYCLE_W-1:0]         point_cycle;
    logic [vtcm_pkg::DUTY_W-1:0]          point_duty;

    modport source (
        output valid, req_type, vario, point_index, point_speed, point_freq,
               point_cycle, point_duty,
        input  ready
    );

    modport sink (
        input  valid, req_type, vario, point_index, point_speed, point_freq,
               point_cycle, point_duty,
        output ready
    );
endinterface

`default_nettype wire

>>> src/vtcm_rsp_if.sv
// ----------------------------------------------------------------------------
// vtcm_rsp_if: result channel of the vario tone curve mapper
// Carries the zone and the tone values of one evaluation.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtcm_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    zone;
    logic [vtcm_pkg::FREQ_W-1:0]   tone_freq;
    logic [vtcm_pkg::CYCLE_W-1:0]  tone_cycle;
    logic [vtcm_pkg::DUTY_W-1:0]   tone_duty;

    modport source (
        output valid, zone, tone_freq, tone_cycle, tone_duty,
        input  ready
    );

    modport sink (
        input  valid, zone, tone_freq, tone_cycle, tone_duty,
        output ready
    );
endinterface

`default_nettype wire

>>> src/vtcm_lerp_unit.sv
// ----------------------------------------------------------------------------
// vtcm_lerp_unit: shared rounding interpolation unit
// Computes a + floor(((b-a)*t*2 + span) / (2*span)) with one multiply and
// a restoring divide that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcm_lerp_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire vtcm_pkg::lerp_req_t  req,
    output vtcm_pkg::lerp_stat_t      stat
);

    localparam int QW = 17;

    typedef enum logic [4:0] {
        L_IDLE = 5'b00001,
        L_MUL  = 5'b00010,
        L_PREP = 5'b00100,
        L_DIV  = 5'b01000,
        L_FIN  = 5'b10000
    } lerp_state_t;

    lerp_state_t                      state_reg, state_next;
    logic [vtcm_pkg::VAL_W-1:0]       a_reg, a_next;
    logic signed [vtcm_pkg::VAL_W:0]  diff_reg, diff_next;
    logic [vtcm_pkg::VAL_W-1:0]       t_reg, t_next;
    logic [vtcm_pkg::VAL_W-1:0]       span_reg, span_next;
    logic signed [33:0]               prod_reg, prod_next;
    logic                             neg_reg, neg_next;
    logic [QW-1:0]                    rem_reg, rem_next;
    logic [QW-1:0]                    work_reg, work_next;
    logic [QW-1:0]                    den_reg, den_next;
    logic [4:0]                       cnt_reg, cnt_next;

    logic signed [33:0] prod_w;
    logic [35:0]        num_w;
    logic [35:0]        mag_w;
    logic [QW:0]        trial_w;
    logic [QW:0]        sub_w;
    logic               ge_w;
    logic [QW:0]        qmag_w;
    logic [QW:0]        q_w;
    logic [QW:0]        res_w;

    assign prod_w  = diff_reg * $signed({1'b0, t_reg});
    assign num_w   = {prod_reg[33], prod_reg, 1'b0} + {20'd0, span_reg};
    assign mag_w   = num_w[35] ? (36'd0 - num_w) : num_w;
    assign trial_w = {rem_reg, work_reg[QW-1]};
    assign sub_w   = trial_w - {1'b0, den_reg};
    assign ge_w    = trial_w >= {1'b0, den_reg};
    assign qmag_w  = {1'b0, work_reg} + {{QW{1'b0}}, (neg_reg && (rem_reg != '0))};
    assign q_w     = neg_reg ? (~qmag_w + 1'b1) : qmag_w;
    assign res_w   = {2'b00, a_reg} + q_w;

    assign stat.done   = (state_reg == L_FIN);
    assign stat.result = res_w[vtcm_pkg::VAL_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        diff_next  = diff_reg;
        t_next     = t_reg;
        span_next  = span_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        rem_next   = rem_reg;
        work_next  = work_reg;
        den_next   = den_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    diff_next  = $signed({1'b0, req.b}) - $signed({1'b0, req.a});
                    t_next     = req.t;
                    span_next  = req.span;
                    state_next = L_MUL;
                end
            end
            L_MUL:
            begin
                prod_next  = prod_w;
                state_next = L_PREP;
            end
            L_PREP:
            begin
                cnt_next = '0;
                den_next = {span_reg, 1'b0};
                if (span_reg == '0)
                begin
                    neg_next   = 1'b0;
                    rem_next   = '0;
                    work_next  = '0;
                    state_next = L_FIN;
                end
                else
                begin
                    neg_next   = num_w[35];
                    rem_next   = mag_w[33:QW];
                    work_next  = mag_w[QW-1:0];
                    state_next = L_DIV;
                end
            end
            L_DIV:
            begin
                rem_next  = ge_w ? sub_w[QW-1:0] : trial_w[QW-1:0];
                work_next = {work_reg[QW-2:0], ge_w};
                cnt_next  = cnt_reg + 5'd1;
                if (cnt_reg == 5'(QW - 1))
                begin
                    state_next = L_FIN;
                end
            end
            L_FIN:
            begin
                state_next = L_IDLE;
            end
            default:
            begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        diff_reg <= diff_next;
        t_reg    <= t_next;
        span_reg <= span_next;
        prod_reg <= prod_next;
        neg_reg  <= neg_next;
        rem_reg  <= rem_next;
        work_reg <= work_next;
        den_reg  <= den_next;
        cnt_reg  <= cnt_next;
    end

endmodule

`default_nettype wire

>>> src/vario_tone_curve_mapper.sv
// ----------------------------------------------------------------------------
// vario_tone_curve_mapper: vertical speed to beeper tone mapper
// Breakpoint table with piecewise linear interpolation of three tone values.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one transaction per item. A write (req_type 0) stores one
//   table point as it is accepted and returns nothing. An evaluate
//   (req_type 1) classifies the speed and returns one transaction on rsp.
//   cfg_we/cfg_index/cfg_data write the five settings; write them only
//   while no evaluation is pending.
// Evaluation steps:
//   Silence, pre-lift and an empty table go from acceptance straight to
//   the output stage. Climb and sink check the first and last points
//   (stopping there when the speed clamps to an end), walk the table one
//   entry per cycle over its single read port, then run the shared
//   multiply and 17-step divide once per tone value. req.ready is low
//   while an evaluation is in progress.
// Reset: clears the control path and loads the setting defaults. Table
//   entries hold garbage until written.
// Stall: a finished result waits in the output register; the next item is
//   accepted and processed meanwhile, and holds only at its own hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module vario_tone_curve_mapper #(
    parameter int MAX_POINTS = vtcm_pkg::MAX_POINTS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    vtcm_req_if.sink                              req,
    vtcm_rsp_if.source                            rsp,
    input  wire logic                             cfg_we,
    input  wire logic [vtcm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [vtcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [AW-1:0] LAST_MAX = AW'(MAX_POINTS - 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_CHK0   = 8'b00000010,
        ST_CHKL   = 8'b00000100,
        ST_SCAN   = 8'b00001000,
        ST_LERP_F = 8'b00010000,
        ST_LERP_C = 8'b00100000,
        ST_LERP_D = 8'b01000000,
        ST_OUT    = 8'b10000000
    } map_state_t;

    logic [vtcm_pkg::COUNT_W-1:0]        point_count_reg;
    logic signed [vtcm_pkg::SPEED_W-1:0] climb_on_reg;
    logic signed [vtcm_pkg::SPEED_W-1:0] climb_off_reg;
    logic signed [vtcm_pkg::SPEED_W-1:0] sink_on_reg;
    logic                                pre_lift_reg;

    vtcm_pkg::tbl_entry_t mem [MAX_POINTS];
    vtcm_pkg::tbl_entry_t rd_data_reg;
    vtcm_pkg::tbl_entry_t wr_entry;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic                 wr_en;

    map_state_t                          state_reg, state_next;
    logic signed [vtcm_pkg::SPEED_W-1:0] v_reg, v_next;
    vtcm_pkg::tbl_entry_t                prev_reg, prev_next;
    vtcm_pkg::tbl_entry_t                cur_reg, cur_next;
    logic [AW-1:0]                       k_reg, k_next;
    logic [vtcm_pkg::VAL_W-1:0]          t_reg, t_next;
    logic [vtcm_pkg::VAL_W-1:0]          span_reg, span_next;
    logic                                start_reg, start_next;
    logic [1:0]                          res_zone_reg, res_zone_next;
    logic [vtcm_pkg::FREQ_W-1:0]         res_freq_reg, res_freq_next;
    logic [vtcm_pkg::CYCLE_W-1:0]        res_cycle_reg, res_cycle_next;
    logic [vtcm_pkg::DUTY_W-1:0]         res_duty_reg, res_duty_next;
    logic                                out_valid_reg, out_valid_next;
    logic [1:0]                          out_zone_reg, out_zone_next;
    logic [vtcm_pkg::FREQ_W-1:0]         out_freq_reg, out_freq_next;
    logic [vtcm_pkg::CYCLE_W-1:0]        out_cycle_reg, out_cycle_next;
    logic [vtcm_pkg::DUTY_W-1:0]         out_duty_reg, out_duty_next;

    logic                  req_fire;
    logic [AW-1:0]         last_idx;
    logic [vtcm_pkg::VAL_W:0] t_full;
    logic [vtcm_pkg::VAL_W:0] span_full;

    vtcm_pkg::lerp_req_t  lerp_req;
    vtcm_pkg::lerp_stat_t lerp_stat;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.zone       = out_zone_reg;
    assign rsp.tone_freq  = out_freq_reg;
    assign rsp.tone_cycle = out_cycle_reg;
    assign rsp.tone_duty  = out_duty_reg;

    assign last_idx = (32'(point_count_reg) > MAX_POINTS) ? LAST_MAX
                    : AW'(point_count_reg - 5'd1);

    assign t_full    = {v_reg[15], v_reg} - {prev_reg.speed[15], prev_reg.speed};
    assign span_full = {rd_data_reg.speed[15], rd_data_reg.speed}
                     - {prev_reg.speed[15], prev_reg.speed};

    // table write port
    assign wr_en = req_fire && (req.req_type == vtcm_pkg::REQ_WRITE)
                 && (32'(req.point_index) < MAX_POINTS);
    assign wr_addr        = AW'(req.point_index);
    assign wr_entry.speed = req.point_speed;
    assign wr_entry.freq  = req.point_freq;
    assign wr_entry.cycle = req.point_cycle;
    assign wr_entry.duty  = req.point_duty;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= vtcm_pkg::RST_POINT_COUNT;
            climb_on_reg    <= vtcm_pkg::RST_CLIMB_ON_LEVEL;
            climb_off_reg   <= vtcm_pkg::RST_CLIMB_OFF_LEVEL;
            sink_on_reg     <= vtcm_pkg::RST_SINK_ON_LEVEL;
            pre_lift_reg    <= vtcm_pkg::RST_PRE_LIFT_ENABLE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vtcm_pkg::CFG_POINT_COUNT:     point_count_reg <= cfg_data[4:0];
                vtcm_pkg::CFG_CLIMB_ON_LEVEL:  climb_on_reg    <= cfg_data;
                vtcm_pkg::CFG_CLIMB_OFF_LEVEL: climb_off_reg   <= cfg_data;
                vtcm_pkg::CFG_SINK_ON_LEVEL:   sink_on_reg     <= cfg_data;
                vtcm_pkg::CFG_PRE_LIFT_ENABLE: pre_lift_reg    <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // shared interpolation unit, one tone value per pass
    always_comb
    begin
        lerp_req.start = start_reg;
        lerp_req.t     = t_reg;
        lerp_req.span  = span_reg;
        unique case (state_reg)
            ST_LERP_C:
            begin
                lerp_req.a = prev_reg.cycle;
                lerp_req.b = cur_reg.cycle;
            end
            ST_LERP_D:
            begin
                lerp_req.a = {9'd0, prev_reg.duty};
                lerp_req.b = {9'd0, cur_reg.duty};
            end
            default:
            begin
                lerp_req.a = {4'd0, prev_reg.freq};
                lerp_req.b = {4'd0, cur_reg.freq};
            end
        endcase
    end

    vtcm_lerp_unit u_lerp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (lerp_req),
        .stat  (lerp_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        t_next         = t_reg;
        span_next      = span_reg;
        start_next     = 1'b0;
        res_zone_next  = res_zone_reg;
        res_freq_next  = res_freq_reg;
        res_cycle_next = res_cycle_reg;
        res_duty_next  = res_duty_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_zone_next  = out_zone_reg;
        out_freq_next  = out_freq_reg;
        out_cycle_next = out_cycle_reg;
        out_duty_next  = out_duty_reg;
        rd_addr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.req_type == vtcm_pkg::REQ_EVAL))
                begin
                    v_next         = req.vario;
                    res_freq_next  = '0;
                    res_cycle_next = '0;
                    res_duty_next  = '0;
                    state_next     = ST_OUT;
                    priority if (req.vario >= climb_on_reg)
                    begin
                        res_zone_next = vtcm_pkg::ZONE_CLIMB;
                        if (point_count_reg != '0)
                        begin
                            state_next = ST_CHK0;
                        end
                    end
                    else if (req.vario <= sink_on_reg)
                    begin
                        res_zone_next = vtcm_pkg::ZONE_SINK;
                        if (point_count_reg != '0)
                        begin
                            state_next = ST_CHK0;
                        end
                    end
                    else if (pre_lift_reg && (req.vario >= climb_off_reg))
                    begin
                        res_zone_next  = vtcm_pkg::ZONE_PRE_LIFT;
                        res_freq_next  = vtcm_pkg::PRE_LIFT_FREQ;
                        res_cycle_next = vtcm_pkg::PRE_LIFT_CYCLE;
                        res_duty_next  = vtcm_pkg::PRE_LIFT_DUTY;
                    end
                    else
                    begin
                        res_zone_next = vtcm_pkg::ZONE_SILENCE;
                    end
                end
            end
            ST_CHK0:
            begin
                if (v_reg <= rd_data_reg.speed)
                begin
                    res_freq_next  = rd_data_reg.freq;
                    res_cycle_next = rd_data_reg.cycle;
                    res_duty_next  = rd_data_reg.duty;
                    state_next     = ST_OUT;
                end
                else
                begin
                    prev_next  = rd_data_reg;
                    rd_addr    = last_idx;
                    state_next = ST_CHKL;
                end
            end
            ST_CHKL:
            begin
                if (v_reg >= rd_data_reg.speed)
                begin
                    res_freq_next  = rd_data_reg.freq;
                    res_cycle_next = rd_data_reg.cycle;
                    res_duty_next  = rd_data_reg.duty;
                    state_next     = ST_OUT;
                end
                else
                begin
                    k_next     = AW'(1);
                    rd_addr    = AW'(1);
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((v_reg >= prev_reg.speed) && (v_reg <= rd_data_reg.speed))
                begin
                    cur_next   = rd_data_reg;
                    t_next     = t_full[vtcm_pkg::VAL_W-1:0];
                    span_next  = span_full[vtcm_pkg::VAL_W-1:0];
                    start_next = 1'b1;
                    state_next = ST_LERP_F;
                end
                else if (k_reg == last_idx)
                begin
                    res_freq_next  = '0;
                    res_cycle_next = '0;
                    res_duty_next  = '0;
                    state_next     = ST_OUT;
                end
                else
                begin
                    prev_next  = rd_data_reg;
                    k_next     = k_reg + 1'b1;
                    rd_addr    = k_reg + 1'b1;
                end
            end
            ST_LERP_F:
            begin
                if (lerp_stat.done)
                begin
                    res_freq_next = lerp_stat.result[vtcm_pkg::FREQ_W-1:0];
                    start_next    = 1'b1;
                    state_next    = ST_LERP_C;
                end
            end
            ST_LERP_C:
            begin
                if (lerp_stat.done)
                begin
                    res_cycle_next = lerp_stat.result;
                    start_next     = 1'b1;
                    state_next     = ST_LERP_D;
                end
            end
            ST_LERP_D:
            begin
                if (lerp_stat.done)
                begin
                    res_duty_next = lerp_stat.result[vtcm_pkg::DUTY_W-1:0];
                    state_next    = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_zone_next  = res_zone_reg;
                    out_freq_next  = res_freq_reg;
                    out_cycle_next = res_cycle_reg;
                    out_duty_next  = res_duty_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg         <= v_next;
        prev_reg      <= prev_next;
        cur_reg       <= cur_next;
        k_reg         <= k_next;
        t_reg         <= t_next;
        span_reg      <= span_next;
        res_zone_reg  <= res_zone_next;
        res_freq_reg  <= res_freq_next;
        res_cycle_reg <= res_cycle_next;
        res_duty_reg  <= res_duty_next;
        out_zone_reg  <= out_zone_next;
        out_freq_reg  <= out_freq_next;
        out_cycle_reg <= out_cycle_next;
        out_duty_reg  <= out_duty_next;
    end

endmodule

`default_nettype wire

>>> src/vtcm_checker.sv
// ----------------------------------------------------------------------------
// vtcm_checker: port-level checks of the vario tone curve mapper
// Watches request and result transactions and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vtcm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              req_type,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [1:0]                        rsp_zone,
    input wire logic [vtcm_pkg::FREQ_W-1:0]       rsp_freq,
    input wire logic [vtcm_pkg::CYCLE_W-1:0]      rsp_cycle,
    input wire logic [vtcm_pkg::DUTY_W-1:0]       rsp_duty
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_silence_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_zone == vtcm_pkg::ZONE_SILENCE)
        |-> (rsp_freq == '0) && (rsp_cycle == '0) && (rsp_duty == '0))
        else $error("silence result carries a tone");

    a_pre_lift_tone: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_zone == vtcm_pkg::ZONE_PRE_LIFT)
        |-> (rsp_freq == vtcm_pkg::PRE_LIFT_FREQ)
            && (rsp_cycle == vtcm_pkg::PRE_LIFT_CYCLE)
            && (rsp_duty == vtcm_pkg::PRE_LIFT_DUTY))
        else $error("pre-lift result differs from the fixed tone");

    a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == vtcm_pkg::REQ_WRITE) |=> req_ready)
        else $error("table write did not complete in one cycle");

    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_type == vtcm_pkg::REQ_EVAL) |=> !req_ready)
        else $error("evaluation overlapped by a new transaction");

endmodule

bind vario_tone_curve_mapper vtcm_checker u_vtcm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_type  (req.req_type),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_zone  (rsp.zone),
    .rsp_freq  (rsp.tone_freq),
    .rsp_cycle (rsp.tone_cycle),
    .rsp_duty  (rsp.tone_duty)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the vario tone curve mapper
// Loads breakpoint tables and zone thresholds, evaluates speeds against them
// and compares every zone and tone transaction with a local prediction of
// the curve lookup, under random pacing on both channels.
// ----------------------------------------------------------------------------

module tb;

    localparam int RANDOM_ITEMS  = 1680;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 100;
    localparam int NPTS          = vtcm_pkg::MAX_POINTS_DEF;

    typedef struct packed {
        logic signed [vtcm_pkg::SPEED_W-1:0] speed;
        logic [1:0]                          zone;
        logic [vtcm_pkg::FREQ_W-1:0]         freq;
        logic [vtcm_pkg::CYCLE_W-1:0]        cycle;
        logic [vtcm_pkg::DUTY_W-1:0]         duty;
    } tone_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [vtcm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [vtcm_pkg::CFG_DATA_W-1:0] cfg_data;

    vtcm_req_if req_ch ();
    vtcm_rsp_if rsp_ch ();

    vario_tone_curve_mapper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    vtcm_pkg::tbl_entry_t                curve_pts [NPTS];
    logic [vtcm_pkg::COUNT_W-1:0]        cur_count     = vtcm_pkg::RST_POINT_COUNT;
    logic signed [vtcm_pkg::SPEED_W-1:0] climb_on_lvl  = vtcm_pkg::RST_CLIMB_ON_LEVEL;
    logic signed [vtcm_pkg::SPEED_W-1:0] climb_off_lvl = vtcm_pkg::RST_CLIMB_OFF_LEVEL;
    logic signed [vtcm_pkg::SPEED_W-1:0] sink_on_lvl   = vtcm_pkg::RST_SINK_ON_LEVEL;
    logic                                lift_en       = vtcm_pkg::RST_PRE_LIFT_ENABLE;

    tone_t pending_tones [$];
    int    mismatch_count = 0;
    bit    quiet_phase    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor(a + (b-a)(v-va)/(vb-va) + 1/2), exact in integers
    function automatic longint tone_lerp(input longint a, input longint b, input longint v,
                                         input longint va, input longint vb);
        longint span;
        longint num;
        longint den;
        longint q;
        span = vb - va;
        if (span <= 0)
            return a;
        num = 2 * (b - a) * (v - va) + span;
        den = 2 * span;
        q = num / den;
        if ((num % den != 0) && (num < 0))
            q = q - 1;
        return a + q;
    endfunction

    function automatic tone_t curve_lookup(input logic signed [vtcm_pkg::SPEED_W-1:0] v,
                                           input logic [1:0] z);
        tone_t  t;
        int     n;
        int     last;
        int     pick;
        longint vi;
        longint va;
        longint vb;
        longint lv;
        t = '0;
        t.zone = z;
        t.speed = v;
        n = (cur_count > NPTS) ? NPTS : int'(cur_count);
        if (n == 0)
            return t;
        last = n - 1;
        vi = v;
        va = curve_pts[0].speed;
        vb = curve_pts[last].speed;
        pick = -1;
        if (vi <= va)
            pick = 0;
        else if (vi >= vb)
            pick = last;
        if (pick >= 0)
        begin
            t.freq  = curve_pts[pick].freq;
            t.cycle = curve_pts[pick].cycle;
            t.duty  = curve_pts[pick].duty;
            return t;
        end
        for (int i = 0; i < last; i++)
        begin
            va = curve_pts[i].speed;
            vb = curve_pts[i+1].speed;
            if (vi >= va && vi <= vb)
            begin
                lv = tone_lerp(longint'(curve_pts[i].freq), longint'(curve_pts[i+1].freq),
                               vi, va, vb);
                t.freq = lv[vtcm_pkg::FREQ_W-1:0];
                lv = tone_lerp(longint'(curve_pts[i].cycle), longint'(curve_pts[i+1].cycle),
                               vi, va, vb);
                t.cycle = lv[vtcm_pkg::CYCLE_W-1:0];
                lv = tone_lerp(longint'(curve_pts[i].duty), longint'(curve_pts[i+1].duty),
                               vi, va, vb);
                t.duty = lv[vtcm_pkg::DUTY_W-1:0];
                return t;
            end
        end
        return t;
    endfunction

    function automatic tone_t predict_tone(input logic signed [vtcm_pkg::SPEED_W-1:0] v);
        tone_t t;
        t = '0;
        t.speed = v;
        t.zone = vtcm_pkg::ZONE_SILENCE;
        if (v >= climb_on_lvl)
            t = curve_lookup(v, vtcm_pkg::ZONE_CLIMB);
        else if (v <= sink_on_lvl)
            t = curve_lookup(v, vtcm_pkg::ZONE_SINK);
        else if (lift_en && v >= climb_off_lvl)
        begin
            t.zone  = vtcm_pkg::ZONE_PRE_LIFT;
            t.freq  = vtcm_pkg::PRE_LIFT_FREQ;
            t.cycle = vtcm_pkg::PRE_LIFT_CYCLE;
            t.duty  = vtcm_pkg::PRE_LIFT_DUTY;
        end
        return t;
    endfunction

    function automatic int rand_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 60)
            return int'($urandom_range(1, 3));
        if (r < 90)
            return int'($urandom_range(4, 20));
        return int'($urandom_range(30, 150));
    endfunction

    function automatic int clamp16(input int x);
        if (x < -32768)
            return -32768;
        if (x > 32767)
            return 32767;
        return x;
    endfunction

    function automatic int pick_edge();
        case ($urandom_range(0, 2))
            0: return -32768;
            1: return 32767;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    function automatic int pick_field(input int max_val);
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 8)
            return 0;
        if (r < 16)
            return max_val;
        return int'($urandom_range(0, max_val));
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic send_item(input logic kind, input logic signed [vtcm_pkg::SPEED_W-1:0] v,
                             input logic [vtcm_pkg::INDEX_W-1:0] idx,
                             input vtcm_pkg::tbl_entry_t pt);
        int gap;
        gap = (quiet_phase || $urandom_range(0, 1)) ? 0 : rand_len();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= kind;
        req_ch.vario       <= v;
        req_ch.point_index <= idx;
        req_ch.point_speed <= pt.speed;
        req_ch.point_freq  <= pt.freq;
        req_ch.point_cycle <= pt.cycle;
        req_ch.point_duty  <= pt.duty;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        if (kind == vtcm_pkg::REQ_WRITE)
            curve_pts[idx] = pt;
        else
            pending_tones.push_back(predict_tone(v));
    endtask

    task automatic write_point(input int idx, input int speed, input int freq,
                               input int cycle, input int duty);
        vtcm_pkg::tbl_entry_t                pt;
        logic [vtcm_pkg::SPEED_W-1:0] noise;
        pt.speed = speed[vtcm_pkg::SPEED_W-1:0];
        pt.freq  = freq[vtcm_pkg::FREQ_W-1:0];
        pt.cycle = cycle[vtcm_pkg::CYCLE_W-1:0];
        pt.duty  = duty[vtcm_pkg::DUTY_W-1:0];
        noise = 16'($urandom_range(0, 65535));
        send_item(vtcm_pkg::REQ_WRITE, noise, idx[vtcm_pkg::INDEX_W-1:0], pt);
    endtask

    task automatic eval_speed(input int v);
        vtcm_pkg::tbl_entry_t         noise;
        logic [vtcm_pkg::INDEX_W-1:0] slot;
        noise.speed = 16'($urandom_range(0, 65535));
        noise.freq  = 12'($urandom_range(0, 4000));
        noise.cycle = 16'($urandom_range(0, 65535));
        noise.duty  = 7'($urandom_range(0, 100));
        slot = 4'($urandom_range(0, 15));
        send_item(vtcm_pkg::REQ_EVAL, v[vtcm_pkg::SPEED_W-1:0], slot, noise);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_tones.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [vtcm_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[vtcm_pkg::CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic apply_config(input int cnt, input int con, input int coff,
                                input int son, input int lift);
        cfg_put(vtcm_pkg::CFG_POINT_COUNT, cnt);
        cfg_put(vtcm_pkg::CFG_CLIMB_ON_LEVEL, con);
        cfg_put(vtcm_pkg::CFG_CLIMB_OFF_LEVEL, coff);
        cfg_put(vtcm_pkg::CFG_SINK_ON_LEVEL, son);
        cfg_put(vtcm_pkg::CFG_PRE_LIFT_ENABLE, lift);
        cfg_we <= 1'b0;
        cur_count     = cnt[vtcm_pkg::COUNT_W-1:0];
        climb_on_lvl  = con[vtcm_pkg::SPEED_W-1:0];
        climb_off_lvl = coff[vtcm_pkg::SPEED_W-1:0];
        sink_on_lvl   = son[vtcm_pkg::SPEED_W-1:0];
        lift_en       = lift[0];
    endtask

    task automatic test_table_load();
        write_point(0, -32768, 4000, 65535, 100);
        write_point(1, -512, 700, 200, 40);
        write_point(2, 256, 1001, 0, 0);
        write_point(3, 32767, 0, 65535, 100);
    endtask

    task automatic test_empty_table();
        eval_speed(-32768);
        eval_speed(-512);
        eval_speed(-511);
        eval_speed(12);
        eval_speed(13);
        eval_speed(37);
        eval_speed(38);
        eval_speed(32767);
    endtask

    task automatic test_interpolation();
        drain_results();
        apply_config(4, 38, 13, -512, 1);
        eval_speed(-32768);
        eval_speed(32767);
        eval_speed(-512);
        eval_speed(-1000);
        eval_speed(38);
        eval_speed(128);
        eval_speed(20);
        eval_speed(0);
    endtask

    task automatic test_zone_priority();
        drain_results();
        apply_config(4, -100, -32768, 100, 0);
        eval_speed(0);
        eval_speed(-200);
        eval_speed(-32768);
        drain_results();
        apply_config(4, 32767, -32768, -32768, 1);
        eval_speed(0);
        eval_speed(-32768);
        eval_speed(32767);
    endtask

    task automatic test_random_curves();
        int sent;
        int n;
        int r;
        int lo;
        int hi;
        int con;
        int coff;
        int son;
        int idx;
        int s;
        int v;
        int tmp;
        int phase_len;
        int spd [NPTS];
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            drain_results();
            quiet_phase = ($urandom_range(0, 4) == 0);
            r = int'($urandom_range(0, 99));
            if (r < 8)
                n = 0;
            else if (r < 16)
                n = 1;
            else if (r < 24)
                n = 2;
            else if (r < 40)
                n = NPTS;
            else
                n = int'($urandom_range(3, NPTS - 1));
            r = int'($urandom_range(0, 99));
            if (r < 70)
            begin
                son  = -int'($urandom_range(100, 2000));
                coff = int'($urandom_range(0, 150)) - 50;
                con  = coff + int'($urandom_range(0, 300));
            end
            else if (r < 85)
            begin
                son  = int'($urandom_range(0, 65535)) - 32768;
                coff = int'($urandom_range(0, 65535)) - 32768;
                con  = int'($urandom_range(0, 65535)) - 32768;
            end
            else
            begin
                son  = pick_edge();
                coff = pick_edge();
                con  = pick_edge();
            end
            apply_config(n, con, coff, son, int'($urandom_range(0, 1)));

            r = int'($urandom_range(0, 99));
            if (r < 75)
            begin
                lo = -int'($urandom_range(300, 4000));
                hi = int'($urandom_range(300, 4000));
            end
            else if (r < 90)
            begin
                lo = -32768;
                hi = 32767;
            end
            else
            begin
                lo = int'($urandom_range(0, 65535)) - 32768;
                hi = clamp16(lo + int'($urandom_range(0, 40)));
            end
            for (int i = 0; i < n; i++)
                spd[i] = lo + int'($urandom_range(0, hi - lo));
            // leave a few tables unordered
            if ($urandom_range(0, 9) != 0)
            begin
                for (int i = 1; i < n; i++)
                    for (int j = i; j > 0 && spd[j-1] > spd[j]; j--)
                    begin
                        tmp = spd[j];
                        spd[j] = spd[j-1];
                        spd[j-1] = tmp;
                    end
            end
            for (int i = 0; i < n; i++)
            begin
                write_point(i, spd[i], pick_field(4000), pick_field(65535), pick_field(100));
                sent++;
            end

            phase_len = int'($urandom_range(40, 160));
            repeat (phase_len)
            begin
                r = int'($urandom_range(0, 99));
                if (r < 2)
                    drain_results();
                if (r < 12)
                begin
                    if (n > 0 && r < 9)
                    begin
                        idx = int'($urandom_range(0, n - 1));
                        s = spd[idx];
                    end
                    else
                    begin
                        idx = int'($urandom_range(0, NPTS - 1));
                        s = int'($urandom_range(0, 65535)) - 32768;
                        if (idx < n)
                            spd[idx] = s;
                    end
                    write_point(idx, s, pick_field(4000), pick_field(65535), pick_field(100));
                end
                else
                begin
                    r = int'($urandom_range(0, 99));
                    if (r < 30 && n > 0)
                        v = spd[$urandom_range(0, n - 1)] + int'($urandom_range(0, 6)) - 3;
                    else if (r < 55)
                        v = lo - 50 + int'($urandom_range(0, hi - lo + 100));
                    else if (r < 72)
                    begin
                        case ($urandom_range(0, 2))
                            0: v = con;
                            1: v = coff;
                            default: v = son;
                        endcase
                        v = v + int'($urandom_range(0, 4)) - 2;
                    end
                    else if (r < 82)
                        v = $urandom_range(0, 1) ? -32768 : 32767;
                    else
                        v = int'($urandom_range(0, 65535)) - 32768;
                    eval_speed(clamp16(v));
                end
                sent++;
            end
        end
        quiet_phase = 1'b0;
    endtask

    initial
    begin : rsp_pacer
        bit hi;
        int rdy_left;
        hi = 1'b0;
        rdy_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rdy_left == 0)
            begin
                if (quiet_phase)
                begin
                    hi = 1'b1;
                    rdy_left = 1;
                end
                else
                begin
                    hi = !hi;
                    rdy_left = rand_len();
                end
            end
            rdy_left--;
            rsp_ch.ready <= hi;
        end
    end

    always @(posedge clk)
    begin : tone_check
        tone_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_tones.size() == 0)
                report_mismatch("result with no evaluation pending, zone", rsp_ch.zone, 0);
            else
            begin
                want = pending_tones.pop_front();
                if (rsp_ch.zone !== want.zone)
                    report_mismatch($sformatf("zone at speed %0d", want.speed),
                                    rsp_ch.zone, want.zone);
                if (rsp_ch.tone_freq !== want.freq)
                    report_mismatch($sformatf("tone_freq at speed %0d", want.speed),
                                    rsp_ch.tone_freq, want.freq);
                if (rsp_ch.tone_cycle !== want.cycle)
                    report_mismatch($sformatf("tone_cycle at speed %0d", want.speed),
                                    rsp_ch.tone_cycle, want.cycle);
                if (rsp_ch.tone_duty !== want.duty)
                    report_mismatch($sformatf("tone_duty at speed %0d", want.speed),
                                    rsp_ch.tone_duty, want.duty);
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("[%0t] no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin : run
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_index          <= vtcm_pkg::CFG_POINT_COUNT;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.req_type    <= vtcm_pkg::REQ_EVAL;
        req_ch.vario       <= '0;
        req_ch.point_index <= '0;
        req_ch.point_speed <= '0;
        req_ch.point_freq  <= '0;
        req_ch.point_cycle <= '0;
        req_ch.point_duty  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_load();
        test_empty_table();
        test_interpolation();
        test_zone_priority();
        test_random_curves();

        drain_results();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
